// ===== hw/rtl/scfp_pkg.sv =====
package scfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HalfW  = 7;
  localparam int unsigned ValueW = 2 * HalfW;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_SET_CODE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_GET_CODE = 1'd1;

  localparam logic [ByteW-1:0] SetCodeRst = 8'h80;
  localparam logic [ByteW-1:0] GetCodeRst = 8'h81;

  // parse phases
  localparam logic [1:0] PH_INDEX = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_HIGH  = 2'd3;

  // result kinds
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] set_code;
    logic [ByteW-1:0] get_code;
  } codes_t;

  typedef struct packed {
    logic              kind;
    logic [HalfW-1:0]  first_index;
    logic [HalfW-1:0]  value_count;
    logic [HalfW-1:0]  value_pos;
    logic [ValueW-1:0] value;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/scfp_byte_if.sv =====
interface scfp_byte_if;
  import scfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/scfp_res_if.sv =====
interface scfp_res_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [HalfW-1:0]  first_index;
  logic [HalfW-1:0]  value_count;
  logic [HalfW-1:0]  value_pos;
  logic [ValueW-1:0] value;
  logic              last;

  modport source (output valid, output kind, output first_index, output value_count,
                  output value_pos, output value, output last, input ready);
  modport sink   (input valid, input kind, input first_index, input value_count,
                  input value_pos, input value, input last, output ready);
endinterface

// ===== hw/rtl/scfp_cfg_if.sv =====
interface scfp_cfg_if;
  import scfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/scfp_parser.sv =====
module scfp_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [scfp_pkg::ByteW-1:0] rx_byte_i,
  input  scfp_pkg::codes_t        codes_i,
  output logic                    res_valid_o,
  output scfp_pkg::res_t          res_o
);
  import scfp_pkg::*;

  logic             receiving_q, receiving_d;
  logic [1:0]       phase_q, phase_d;
  logic             is_get_q, is_get_d;
  logic [HalfW-1:0] index_q, index_d;
  logic [HalfW-1:0] count_q, count_d;
  logic [HalfW-1:0] pos_q, pos_d;
  logic [HalfW-1:0] low_q, low_d;

  logic             is_hdr;
  logic [HalfW-1:0] data7;
  logic             hit_set, hit_get;
  logic [HalfW:0]   pos_inc;
  logic             is_last;

  assign is_hdr  = rx_byte_i[ByteW-1];
  assign data7   = rx_byte_i[HalfW-1:0];
  assign hit_set = (rx_byte_i == codes_i.set_code);
  assign hit_get = (rx_byte_i == codes_i.get_code);
  assign pos_inc = {1'b0, pos_q} + {{HalfW{1'b0}}, 1'b1};
  assign is_last = (pos_inc >= {1'b0, count_q});

  always_comb begin
    receiving_d = receiving_q;
    phase_d     = phase_q;
    is_get_d    = is_get_q;
    index_d     = index_q;
    count_d     = count_q;
    pos_d       = pos_q;
    low_d       = low_q;
    res_valid_o = 1'b0;
    res_o.kind        = KIND_SET;
    res_o.first_index = index_q;
    res_o.value_count = count_q;
    res_o.value_pos   = pos_q;
    res_o.value       = {data7, low_q};
    res_o.last        = is_last;

    if (is_hdr) begin
      // any header closes the open frame; a known code opens a new one
      receiving_d = hit_set || hit_get;
      phase_d     = PH_INDEX;
      pos_d       = '0;
      if (hit_set || hit_get) begin
        is_get_d = !hit_set;
      end
    end else if (receiving_q) begin
      case (phase_q)
        PH_INDEX: begin
          index_d = data7;
          phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          count_d = data7;
          res_o.value_count = data7;
          if (is_get_q) begin
            receiving_d       = 1'b0;
            phase_d           = PH_INDEX;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_GET;
            res_o.value_pos   = '0;
            res_o.value       = '0;
            res_o.last        = 1'b1;
          end else begin
            pos_d = '0;
            if (data7 == '0) begin
              // empty set frame closes right here
              receiving_d = 1'b0;
              phase_d     = PH_INDEX;
            end else begin
              phase_d = PH_LOW;
            end
          end
        end
        PH_LOW: begin
          low_d   = data7;
          phase_d = PH_HIGH;
        end
        PH_HIGH: begin
          res_valid_o = 1'b1;
          if (is_last) begin
            receiving_d = 1'b0;
            phase_d     = PH_INDEX;
          end else begin
            pos_d   = pos_inc[HalfW-1:0];
            phase_d = PH_LOW;
          end
        end
        default: begin
          phase_d = PH_INDEX;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      phase_q     <= PH_INDEX;
      is_get_q    <= 1'b0;
      index_q     <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      low_q       <= '0;
    end else if (step_i) begin
      receiving_q <= receiving_d;
      phase_q     <= phase_d;
      is_get_q    <= is_get_d;
      index_q     <= index_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      low_q       <= low_d;
    end
  end

endmodule

// ===== hw/rtl/seven_bit_command_frame_parser.sv =====
// channel   dir  modport  carries
// rx_i      in   sink     rx_byte, one received byte per request
// res_o     out  source   kind, first_index, value_count, value_pos, value, last
// cfg_i     in   sink     index (0 set_code, 1 get_code), data
//
// one byte accepted per cycle when the result side keeps up
// a byte waits in the input register until parsed, its result is then registered in the result register
// bytes with no result pass through the input register and leave nothing behind
// a stalled result holds the input register; rx_i.ready falls only then
// async active-low reset clears parse state and reloads both codes
module seven_bit_command_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  scfp_byte_if.sink  rx_i,
  scfp_res_if.source res_o,
  scfp_cfg_if.sink   cfg_i
);
  import scfp_pkg::*;

  // configuration registers, always ready
  codes_t codes_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // result register
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;

  // parser step outputs
  logic             step;
  logic             out_free;
  logic             par_valid;
  res_t             par_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.set_code <= SetCodeRst;
      codes_q.get_code <= GetCodeRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SET_CODE: codes_q.set_code <= cfg_i.data;
        REG_GET_CODE: codes_q.get_code <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // result register frees up this cycle if empty or being taken
  assign out_free   = !out_valid_q || res_o.ready;
  // the held byte is parsed once there is room for a possible result
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  scfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .codes_i     (codes_q),
    .res_valid_o (par_valid),
    .res_o       (par_res)
  );

  assign out_valid_d = (out_valid_q && !res_o.ready) || (step && par_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && par_valid) begin
      out_res_q <= par_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_res_q.kind;
  assign res_o.first_index = out_res_q.first_index;
  assign res_o.value_count = out_res_q.value_count;
  assign res_o.value_pos   = out_res_q.value_pos;
  assign res_o.value       = out_res_q.value;
  assign res_o.last        = out_res_q.last;

endmodule
